// File: rtl/core/chkm_pkg.sv
// Package for the click/hold key macro block: action and source codes,
// register indexes, and the state, configuration and result records.
// No dependencies.
`default_nettype none

package chkm_pkg;

	// Action codes in the click_action and hold_action registers.
	// Codes 5 to 7 are unused and do nothing.
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_KEY     = 3'd1,
		ACT_PIN     = 3'd2,
		ACT_PATTERN = 3'd3,
		ACT_TOGGLE  = 3'd4
	} action_t;

	// Where the keys of the running sequence come from.
	typedef enum logic [1:0] {
		SRC_CLICK = 2'd0,
		SRC_HOLD  = 2'd1,
		SRC_PIN   = 2'd2
	} src_t;

	// LED request codes.
	localparam logic [1:0] LED_NONE    = 2'd0;
	localparam logic [1:0] LED_PATTERN = 2'd1;
	localparam logic [1:0] LED_LIGHTS  = 2'd2;

	// Key code that reports a released key.
	localparam logic [7:0] KEY_RELEASE = 8'd0;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_CLICK_ACTION = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLICK_KEY    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_ACTION  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_KEY     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PIN_CODE     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_KEY_GAP      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME    = 3'd6;

	localparam logic [7:0]  KEY_GAP_RST   = 8'd30;
	localparam logic [15:0] HOLD_TIME_RST = 16'd500;

	typedef struct packed {
		logic [2:0]  click_action;
		logic [7:0]  click_key;
		logic [2:0]  hold_action;
		logic [7:0]  hold_key;
		logic [31:0] pin_code;
		logic [7:0]  key_gap;
		logic [15:0] hold_time;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  gap_count;
		logic [15:0] held_ticks;
		logic        last_level;
		src_t        seq_source;
		logic [2:0]  seq_length;
		logic [2:0]  seq_position;
		logic        release_pending;
	} state_t;

	typedef struct packed {
		logic       report_made;
		logic [7:0] key_code;
		logic [1:0] led_request;
	} result_t;

	localparam cfg_t CFG_RST = '{
		click_action: ACT_NONE,
		click_key:    8'd0,
		hold_action:  ACT_NONE,
		hold_key:     8'd0,
		pin_code:     32'd0,
		key_gap:      KEY_GAP_RST,
		hold_time:    HOLD_TIME_RST
	};

	localparam state_t STATE_RST = '{
		gap_count:       8'd0,
		held_ticks:      16'd0,
		last_level:      1'b0,
		seq_source:      SRC_CLICK,
		seq_length:      3'd0,
		seq_position:    3'd0,
		release_pending: 1'b0
	};

endpackage

`default_nettype wire

// File: rtl/core/click_hold_key_macro.sv
// Top level of the click/hold key macro: configuration registers, state
// registers and the result register. Depends on chkm_pkg and chkm_step.
`default_nettype none

// Usage
// The input channel (in_valid/in_ready) carries one item per frame tick
// (cmd 0, with the button level) or per report poll (cmd 1). Every item
// yields exactly one result item on the output channel (out_valid/out_ready):
// report_made, key_code and led_request.
// The block updates its state in the cycle an item is accepted and places
// the result in an output register, so the result is valid in the cycle after
// acceptance. A new item is accepted every cycle while the receiver keeps
// up: in_ready is high whenever the output register is empty or being
// emptied in the same cycle. When the receiver stalls, the result holds
// and in_ready drops until the result is taken.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per accepted write; indexes beyond
// the register list are ignored. Write it only while the block is idle.
// Reset clears the sequence, hold and gap state, sets key_gap to 30 and
// hold_time to 500, and empties the output register.
// PIN_DIGITS sets how many bytes of pin_code the pin action types.
module click_hold_key_macro
	import chkm_pkg::*;
#(
	parameter int unsigned PIN_DIGITS = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 cmd,
	input  wire                 button_level,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                report_made,
	output logic [7:0]          key_code,
	output logic [1:0]          led_request,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [REG_IDX_W-1:0] cfg_index,
	input  wire [31:0]          cfg_data
);

	localparam logic [2:0] PinLen = 3'(PIN_DIGITS);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_next;
	result_t res;
	result_t res_q;
	logic    res_valid_q;
	logic    in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !res_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLICK_ACTION: cfg_q.click_action <= cfg_data[2:0];
				REG_CLICK_KEY:    cfg_q.click_key    <= cfg_data[7:0];
				REG_HOLD_ACTION:  cfg_q.hold_action  <= cfg_data[2:0];
				REG_HOLD_KEY:     cfg_q.hold_key     <= cfg_data[7:0];
				REG_PIN_CODE:     cfg_q.pin_code     <= cfg_data;
				REG_KEY_GAP:      cfg_q.key_gap      <= cfg_data[7:0];
				REG_HOLD_TIME:    cfg_q.hold_time    <= cfg_data[15:0];
				default:          ;
			endcase
		end
	end

	// All of the per-item work happens in one pass of this logic.
	chkm_step #(
		.PIN_LEN (PinLen)
	) u_step (
		.cfg          (cfg_q),
		.st           (st_q),
		.cmd          (cmd),
		.button_level (button_level),
		.st_next      (st_next),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				st_q <= st_next;
			end
			if (in_fire) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// The result payload needs no reset; it is qualified by res_valid_q.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

	assign out_valid   = res_valid_q;
	assign report_made = res_q.report_made;
	assign key_code    = res_q.key_code;
	assign led_request = res_q.led_request;

	// Every accepted item leaves a result in the output register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("accepted item produced no result");

	// A poll while the gap countdown runs never yields a report.
	a_gap_blocks_poll: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd && (st_q.gap_count != 8'd0) |=> !report_made)
		else $error("report made while gap countdown was running");

	// An owed release is reported first, as a released key.
	a_release_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd && (st_q.gap_count == 8'd0) && st_q.release_pending
		|=> report_made && (key_code == KEY_RELEASE))
		else $error("owed key release was not reported");

	// Polls never raise an LED request.
	a_poll_no_led: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd |=> led_request == LED_NONE)
		else $error("led request raised on a poll");

endmodule

`default_nettype wire

// File: rtl/core/chkm_step.sv
// Next-state and result logic of the click/hold key macro for one item.
// Purely combinational; depends on chkm_pkg.
`default_nettype none

module chkm_step
	import chkm_pkg::*;
#(
	parameter logic [2:0] PIN_LEN = 3'd4
) (
	input  var cfg_t    cfg,
	input  var state_t  st,
	input  wire         cmd,
	input  wire         button_level,
	output var state_t  st_next,
	output var result_t res
);

	logic       below_hold;
	logic       fire_hold;
	logic       fire_click;
	logic [2:0] act;
	src_t       key_src;
	logic [7:0] seq_key;

	assign below_hold = st.held_ticks < cfg.hold_time;
	// The hold fires on the tick at which the count reaches hold_time.
	assign fire_hold  = (cmd == 1'b0) && button_level && st.last_level && below_hold
		&& ((st.held_ticks + 16'd1) >= cfg.hold_time);
	assign fire_click = (cmd == 1'b0) && !button_level && st.last_level && below_hold;
	assign act        = fire_hold ? cfg.hold_action : cfg.click_action;
	assign key_src    = fire_hold ? SRC_HOLD : SRC_CLICK;

	always_comb begin
		case (st.seq_source)
			SRC_CLICK: seq_key = cfg.click_key;
			SRC_HOLD:  seq_key = cfg.hold_key;
			default:   seq_key = cfg.pin_code[{st.seq_position[1:0], 3'b000} +: 8];
		endcase
	end

	always_comb begin
		st_next = st;
		res     = '{report_made: 1'b0, key_code: KEY_RELEASE, led_request: LED_NONE};
		if (cmd == 1'b0) begin
			if (st.gap_count != 8'd0) begin
				st_next.gap_count = st.gap_count - 8'd1;
			end
			if (button_level && !st.last_level) begin
				st_next.held_ticks = 16'd0;
			end else if (button_level && st.last_level && below_hold) begin
				st_next.held_ticks = st.held_ticks + 16'd1;
			end
			st_next.last_level = button_level;
			if (fire_hold || fire_click) begin
				case (act)
					ACT_KEY: begin
						st_next.seq_source   = key_src;
						st_next.seq_length   = 3'd1;
						st_next.seq_position = 3'd0;
					end
					ACT_PIN: begin
						st_next.seq_source   = SRC_PIN;
						st_next.seq_length   = PIN_LEN;
						st_next.seq_position = 3'd0;
					end
					ACT_PATTERN: res.led_request = LED_PATTERN;
					ACT_TOGGLE:  res.led_request = LED_LIGHTS;
					default:     ;
				endcase
			end
		end else if (st.gap_count == 8'd0) begin
			// An owed release always goes out before the next key press.
			if (st.release_pending) begin
				st_next.release_pending = 1'b0;
				st_next.gap_count       = cfg.key_gap;
				res.report_made         = 1'b1;
			end else if (st.seq_position < st.seq_length) begin
				st_next.gap_count       = cfg.key_gap;
				st_next.seq_position    = st.seq_position + 3'd1;
				st_next.release_pending = 1'b1;
				res.report_made         = 1'b1;
				res.key_code            = seq_key;
			end
		end
	end

endmodule

`default_nettype wire

// File: bench/click_hold_key_macro_test.sv
// Testbench for click_hold_key_macro: directed steps with typed-in results, then
// randomized phases of button gestures and report polls checked against a predictor.
// Depends on chkm_pkg and click_hold_key_macro.
`default_nettype none

module click_hold_key_macro_test;
	import chkm_pkg::*;

	localparam int unsigned CLK_HALF = 4;
	localparam int unsigned CLK_PERIOD = 2 * CLK_HALF;
	localparam int unsigned PIN_KEYS = 4;
	// The result register is loaded at the edge that accepts an item, so
	// a handful of cycles is plenty to let a stray result show up.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam int unsigned WATCHDOG_CYCLES = 400_000;

	// Item kinds and button levels on the input channel.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_POLL = 1'b1;
	localparam logic RELEASED = 1'b0;
	localparam logic PRESSED = 1'b1;

	// Register index past the end of the list; the block must ignore it.
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam result_t QUIET = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_TICK;
	logic button_level = RELEASED;
	logic out_valid;
	logic out_ready = 1'b0;
	logic report_made;
	logic [7:0] key_code;
	logic [1:0] led_request;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	click_hold_key_macro #(
		.PIN_DIGITS(PIN_KEYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.button_level(button_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.report_made(report_made),
		.key_code(key_code),
		.led_request(led_request),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor. It keeps its own copy of the registers and of the macro
	// state, and it is advanced once for every item the block accepts.
	// Registers only change while the block is idle, so the predictor can
	// run at the moment an item is accepted.
	// ------------------------------------------------------------------
	cfg_t shadow_regs = CFG_RST;
	state_t macro_state = STATE_RST;

	// Results still owed by the block, oldest first.
	result_t pending_results[$];
	int error_count = 0;

	function automatic void apply_reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			REG_CLICK_ACTION: shadow_regs.click_action = data[2:0];
			REG_CLICK_KEY:    shadow_regs.click_key = data[7:0];
			REG_HOLD_ACTION:  shadow_regs.hold_action = data[2:0];
			REG_HOLD_KEY:     shadow_regs.hold_key = data[7:0];
			REG_PIN_CODE:     shadow_regs.pin_code = data;
			REG_KEY_GAP:      shadow_regs.key_gap = data[7:0];
			REG_HOLD_TIME:    shadow_regs.hold_time = data[15:0];
			default: ;
		endcase
	endfunction

	// Starts a key sequence or raises an LED request. The unused action
	// codes fall through and do nothing.
	function automatic logic [1:0] fire_action(logic [2:0] act, src_t key_src);
		fire_action = LED_NONE;
		case (act)
			ACT_KEY: begin
				macro_state.seq_source = key_src;
				macro_state.seq_length = 3'd1;
				macro_state.seq_position = 3'd0;
			end
			ACT_PIN: begin
				macro_state.seq_source = SRC_PIN;
				macro_state.seq_length = 3'(PIN_KEYS);
				macro_state.seq_position = 3'd0;
			end
			ACT_PATTERN: fire_action = LED_PATTERN;
			ACT_TOGGLE:  fire_action = LED_LIGHTS;
			default: ;
		endcase
	endfunction

	function automatic result_t macro_step(logic c, logic lvl);
		result_t r;
		r = QUIET;
		if (c == CMD_TICK) begin
			if (macro_state.gap_count != 8'd0)
				macro_state.gap_count--;
			if (lvl && !macro_state.last_level) begin
				macro_state.held_ticks = 16'd0;
			end else if (lvl && macro_state.last_level &&
					macro_state.held_ticks < shadow_regs.hold_time) begin
				macro_state.held_ticks++;
				if (macro_state.held_ticks >= shadow_regs.hold_time)
					r.led_request = fire_action(shadow_regs.hold_action, SRC_HOLD);
			end else if (!lvl && macro_state.last_level &&
					macro_state.held_ticks < shadow_regs.hold_time) begin
				r.led_request = fire_action(shadow_regs.click_action, SRC_CLICK);
			end
			macro_state.last_level = lvl;
		end else if (macro_state.gap_count == 8'd0) begin
			// An owed release always goes out before the next key press.
			if (macro_state.release_pending) begin
				macro_state.release_pending = 1'b0;
				macro_state.gap_count = shadow_regs.key_gap;
				r.report_made = 1'b1;
				r.key_code = KEY_RELEASE;
			end else if (macro_state.seq_position < macro_state.seq_length) begin
				// Key codes come from the registers as they are at poll time.
				case (macro_state.seq_source)
					SRC_CLICK: r.key_code = shadow_regs.click_key;
					SRC_HOLD:  r.key_code = shadow_regs.hold_key;
					default:   r.key_code =
						shadow_regs.pin_code[8 * macro_state.seq_position[1:0] +: 8];
				endcase
				macro_state.gap_count = shadow_regs.key_gap;
				macro_state.seq_position++;
				macro_state.release_pending = 1'b1;
				r.report_made = 1'b1;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker. Outputs are sampled at the rising edge, before the
	// block's registers move, so each accepted result is compared with the
	// oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item arrived with no item outstanding: made %0d key %0h led %0d",
					report_made, key_code, led_request);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (report_made !== want.report_made) begin
					$error("report_made: expected %0d, got %0d", want.report_made, report_made);
					error_count++;
				end
				if (key_code !== want.key_code) begin
					$error("key_code: expected %0h, got %0h", want.key_code, key_code);
					error_count++;
				end
				if (led_request !== want.led_request) begin
					$error("led_request: expected %0d, got %0d", want.led_request, led_request);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver. It switches between stretches of steady readiness, coin
	// flip stalls and mostly stalled stretches, so results back up and
	// in_ready drops at every point of a gesture or a poll run.
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_stretch = 0;

	always @(posedge clk) begin
		if (stall_stretch == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_stretch = $urandom_range(8, 64);
		end
		stall_stretch--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Sender. Items go out in bursts of random length; between bursts the
	// input valid drops for a random pause. A burst may also follow directly.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int items_sent = 0;
	logic cur_level = RELEASED;

	task automatic send_item(logic c, logic lvl, bit pinned = 1'b0, result_t want = QUIET);
		int gap;
		result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 32);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cfg_valid <= 1'b0;
		in_valid <= 1'b1;
		cmd <= c;
		button_level <= lvl;
		do @(posedge clk); while (!in_ready);
		predicted = macro_step(c, lvl);
		pending_results.push_back(pinned ? want : predicted);
		if (c == CMD_TICK)
			cur_level = lvl;
		items_sent++;
	endtask

	task automatic tick(logic lvl);
		send_item(CMD_TICK, lvl);
	endtask

	// Lets the block go idle: no item in flight and every result taken.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The caller drops cfg_valid later; a second write in a row keeps it
	// high and only swaps index and data.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, data);
	endtask

	// Fills the bits above a register's width with noise; the block must
	// drop them.
	function automatic logic [31:0] with_junk(logic [31:0] val, logic [31:0] mask);
		return ($urandom & ~mask) | (val & mask);
	endfunction

	function automatic logic [2:0] pick_action();
		if ($urandom_range(0, 1))
			return 3'($urandom_range(0, 7));
		return 3'($urandom_range(ACT_KEY, ACT_PIN));
	endfunction

	// ------------------------------------------------------------------
	// Directed steps. Every expected result here follows from the register
	// values by inspection, so it is typed in next to the item.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic cfg_write;
		logic [REG_IDX_W-1:0] idx;
		logic [31:0] data;
		logic c;
		logic lvl;
		logic pinned;
		result_t want;
	} step_row_t;

	step_row_t directed_rows[$];

	task automatic add_cfg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
		directed_rows.push_back('{1'b1, idx, data, CMD_TICK, RELEASED, 1'b0, QUIET});
	endtask

	task automatic add_item(logic c, logic lvl, result_t want);
		directed_rows.push_back('{1'b0, '0, 32'd0, c, lvl, 1'b1, want});
	endtask

	task automatic build_directed();
		// After reset: nothing queued, both actions are none.
		add_item(CMD_POLL, RELEASED, QUIET);
		add_item(CMD_TICK, PRESSED, QUIET);
		add_item(CMD_TICK, RELEASED, QUIET);
		// Click types one key, hold types the pin, shortest nonzero hold and gap.
		add_cfg(REG_CLICK_ACTION, 32'(ACT_KEY));
		add_cfg(REG_CLICK_KEY, 32'hFF);
		add_cfg(REG_HOLD_ACTION, 32'(ACT_PIN));
		add_cfg(REG_PIN_CODE, 32'h0180_7FFE);
		add_cfg(REG_HOLD_TIME, 32'd1);
		add_cfg(REG_KEY_GAP, 32'd1);
		add_item(CMD_TICK, PRESSED, QUIET);
		add_item(CMD_TICK, RELEASED, QUIET);
		add_item(CMD_POLL, RELEASED, {1'b1, 8'hFF, LED_NONE});
		// The gap is still running, so this poll yields nothing.
		add_item(CMD_POLL, RELEASED, QUIET);
		add_item(CMD_TICK, RELEASED, QUIET);
		add_item(CMD_POLL, RELEASED, {1'b1, KEY_RELEASE, LED_NONE});
		// Zero gap: polls are served back to back.
		add_cfg(REG_KEY_GAP, 32'd0);
		add_item(CMD_TICK, PRESSED, QUIET);
		add_item(CMD_TICK, PRESSED, QUIET);
		// Released after the hold fired: no click.
		add_item(CMD_TICK, RELEASED, QUIET);
		add_item(CMD_POLL, RELEASED, {1'b1, 8'hFE, LED_NONE});
		add_item(CMD_POLL, RELEASED, {1'b1, KEY_RELEASE, LED_NONE});
		add_item(CMD_POLL, RELEASED, {1'b1, 8'h7F, LED_NONE});
		add_item(CMD_POLL, RELEASED, {1'b1, KEY_RELEASE, LED_NONE});
		add_item(CMD_POLL, RELEASED, {1'b1, 8'h80, LED_NONE});
		add_item(CMD_POLL, RELEASED, {1'b1, KEY_RELEASE, LED_NONE});
		add_item(CMD_POLL, RELEASED, {1'b1, 8'h01, LED_NONE});
		add_item(CMD_POLL, RELEASED, {1'b1, KEY_RELEASE, LED_NONE});
		// Sequence used up.
		add_item(CMD_POLL, RELEASED, QUIET);
		// LED actions on click and on hold.
		add_cfg(REG_CLICK_ACTION, 32'(ACT_PATTERN));
		add_cfg(REG_HOLD_ACTION, 32'(ACT_TOGGLE));
		add_item(CMD_TICK, PRESSED, QUIET);
		add_item(CMD_TICK, RELEASED, {1'b0, 8'd0, LED_PATTERN});
		add_item(CMD_TICK, PRESSED, QUIET);
		add_item(CMD_TICK, PRESSED, {1'b0, 8'd0, LED_LIGHTS});
	endtask

	// ------------------------------------------------------------------
	// Random phase. Registers are rewritten while idle; the open sequence
	// and any owed release carry over, so keys read from new register
	// values mid-sequence. Most of the phase is well-formed gestures and
	// poll runs that wait out the gap; the rest is noise and hold-offs.
	// ------------------------------------------------------------------
	task automatic run_phase(logic [7:0] gap_val, logic [15:0] hold_val, bit poke_unused);
		int target;
		int k;
		int polls;
		int lim;
		wait_results_drained();
		write_reg(REG_CLICK_ACTION, with_junk(32'(pick_action()), 32'h7));
		write_reg(REG_CLICK_KEY, with_junk($urandom, 32'hFF));
		write_reg(REG_HOLD_ACTION, with_junk(32'(pick_action()), 32'h7));
		write_reg(REG_HOLD_KEY, with_junk($urandom, 32'hFF));
		write_reg(REG_PIN_CODE, $urandom);
		write_reg(REG_KEY_GAP, with_junk(32'(gap_val), 32'hFF));
		write_reg(REG_HOLD_TIME, with_junk(32'(hold_val), 32'hFFFF));
		if (poke_unused)
			write_reg(REG_UNUSED, $urandom);
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// Short click: released before the hold time is reached.
					if (cur_level)
						tick(RELEASED);
					tick(PRESSED);
					if (shadow_regs.hold_time == 16'd0)
						lim = 5;
					else
						lim = (shadow_regs.hold_time > 16'd31) ? 30 :
							int'(shadow_regs.hold_time) - 1;
					k = $urandom_range(0, lim);
					repeat (k) tick(PRESSED);
					tick(RELEASED);
				end
				3, 4: begin
					// Long hold: through hold times up to 40, at times a bit past; else a shorter press.
					if (cur_level)
						tick(RELEASED);
					tick(PRESSED);
					if (shadow_regs.hold_time <= 16'd40)
						k = int'(shadow_regs.hold_time) + int'($urandom_range(0, 3));
					else
						k = $urandom_range(0, 30);
					repeat (k) tick(PRESSED);
					tick(RELEASED);
				end
				5, 6, 7: begin
					// Poll run: each poll is followed by ticks that either wait
					// out the whole gap or only part of it.
					polls = (shadow_regs.key_gap > 8'd16) ? 1 : $urandom_range(1, 6);
					repeat (polls) begin
						send_item(CMD_POLL, 1'($urandom_range(0, 1)));
						if ($urandom_range(0, 1))
							k = int'(shadow_regs.key_gap);
						else
							k = $urandom_range(0, shadow_regs.key_gap);
						repeat (k) tick(cur_level);
					end
				end
				8: begin
					repeat ($urandom_range(1, 8))
						send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
				default: begin
					// Hold-off: now and then the sender waits for every result before going on.
					if ($urandom_range(0, 3) == 0)
						wait_results_drained();
				end
			endcase
		end
	endtask

	initial begin
		step_row_t row;
		bit prev_cfg;
		build_directed();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_cfg = 1'b0;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.cfg_write) begin
				if (!prev_cfg)
					wait_results_drained();
				write_reg(row.idx, row.data);
			end else begin
				send_item(row.c, row.lvl, row.pinned, row.want);
			end
			prev_cfg = row.cfg_write;
		end

		// Extremes first: longest gap, shortest nonzero gap with hold disabled by a
		// zero hold time, zero gap with the longest hold time; then random.
		run_phase(8'd255, 16'd3, 1'b0);
		run_phase(8'd1, 16'd0, 1'b1);
		run_phase(8'd0, 16'd65535, 1'b0);
		repeat (4)
			run_phase(8'($urandom_range(0, 6)), 16'($urandom_range(1, 16)), 1'b0);

		wait_results_drained();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(WATCHDOG_CYCLES * CLK_PERIOD);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
